// ===== src/rpa_pkg.sv =====
// ---------------------------------------------------------------------------
// rpa_pkg: shared constants for the axis-angle rotation unit
// Holds the arctangent table, the gain start value and fraction formats.
// ---------------------------------------------------------------------------
package rpa_pkg;

	localparam int COORD_W_DEF  = 32;
	localparam int AXIS_W_DEF   = 16;
	localparam int ANGLE_W_DEF  = 16;
	localparam int STAGES_DEF   = 16;
	localparam int TABLE_LEN    = 24;
	localparam int MAT_FRAC     = 28;
	localparam int CW           = 34;   // CORDIC x/y width, Q2.30 plus guard
	localparam int ZW           = 33;   // residual phase width
	localparam int MW           = 34;   // matrix term width, Q.28
	localparam logic signed [CW-1:0] CORDIC_START = 34'sd652032874;

	function automatic logic signed [ZW-1:0] atan_lut(input logic [4:0] idx);
		logic signed [ZW-1:0] v;
		case (idx)
			5'd0:    v = 33'sh020000000;
			5'd1:    v = 33'sh012E4051E;
			5'd2:    v = 33'sh009FB385B;
			5'd3:    v = 33'sh0051111D4;
			5'd4:    v = 33'sh0028B0D43;
			5'd5:    v = 33'sh00145D7E1;
			5'd6:    v = 33'sh000A2F61E;
			5'd7:    v = 33'sh000517C55;
			5'd8:    v = 33'sh00028BE53;
			5'd9:    v = 33'sh000145F2F;
			5'd10:   v = 33'sh0000A2F98;
			5'd11:   v = 33'sh0000517CC;
			5'd12:   v = 33'sh000028BE6;
			5'd13:   v = 33'sh0000145F3;
			5'd14:   v = 33'sh00000A2FA;
			5'd15:   v = 33'sh00000517D;
			5'd16:   v = 33'sh0000028BE;
			5'd17:   v = 33'sh00000145F;
			5'd18:   v = 33'sh000000A30;
			5'd19:   v = 33'sh000000518;
			5'd20:   v = 33'sh00000028C;
			5'd21:   v = 33'sh000000146;
			5'd22:   v = 33'sh0000000A3;
			5'd23:   v = 33'sh000000051;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// ===== src/rotate_point_about_axis_unit.sv =====
// ---------------------------------------------------------------------------
// rotate_point_about_axis_unit: rotate a point about an axis by a binary angle
// Path: CORDIC micro-rotation stages, axis products, matrix, products, row sums, output register.
// Throughput: one word per cycle; the pipeline advances whenever the output
// register is free or being drained, so stalls lose and repeat nothing.
// Reset: arst_n clears all valid bits asynchronously; data is not reset.
// ---------------------------------------------------------------------------
module rotate_point_about_axis_unit #(
	parameter int COORD_WIDTH   = rpa_pkg::COORD_W_DEF,
	parameter int AXIS_WIDTH    = rpa_pkg::AXIS_W_DEF,
	parameter int ANGLE_WIDTH   = rpa_pkg::ANGLE_W_DEF,
	parameter int SINCOS_STAGES = rpa_pkg::STAGES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [COORD_WIDTH-1:0] point_x,
	input  logic signed [COORD_WIDTH-1:0] point_y,
	input  logic signed [COORD_WIDTH-1:0] point_z,
	input  logic signed [AXIS_WIDTH-1:0]  axis_x,
	input  logic signed [AXIS_WIDTH-1:0]  axis_y,
	input  logic signed [AXIS_WIDTH-1:0]  axis_z,
	input  logic [ANGLE_WIDTH-1:0]        turn_angle,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [COORD_WIDTH-1:0] rotated_x,
	output logic signed [COORD_WIDTH-1:0] rotated_y,
	output logic signed [COORD_WIDTH-1:0] rotated_z
);
	import rpa_pkg::*;

	localparam int NC  = (SINCOS_STAGES < TABLE_LEN) ? SINCOS_STAGES : TABLE_LEN;
	localparam int AF  = AXIS_WIDTH - 2;
	localparam int LAT = NC + 4;            // stages ahead of the output register
	localparam int PW  = COORD_WIDTH + MW;  // product width
	localparam int SW  = PW + 2;            // row sum width

	// One global enable: the whole pipe advances unless a full output is held.
	logic adv;
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	// Valid bits travel alongside the data.
	logic [LAT-1:0] vld_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end

	// Delay point and axis alongside the CORDIC.
	logic signed [COORD_WIDTH-1:0] p_d [NC+1][3];
	logic signed [AXIS_WIDTH-1:0]  a_d [NC+1][3];
	assign p_d[0][0] = point_x;
	assign p_d[0][1] = point_y;
	assign p_d[0][2] = point_z;
	assign a_d[0][0] = axis_x;
	assign a_d[0][1] = axis_y;
	assign a_d[0][2] = axis_z;
	for (genvar k = 0; k < NC; k++) begin : g_dly
		always_ff @(posedge clk) begin
			if (adv) begin
				p_d[k+1] <= p_d[k];
				a_d[k+1] <= a_d[k];
			end
		end
	end

	logic signed [MW-1:0] cos_c, sin_c;
	rpa_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH), .STAGES(SINCOS_STAGES)) u_cordic (
		.clk(clk), .arst_n(arst_n), .en(adv), .angle(turn_angle),
		.cos_q(cos_c), .sin_q(sin_c)
	);

	// Stage 1: axis products ab (rounded to Q.28) and a*sin (rounded to Q.28).
	localparam int ABW = 2 * AXIS_WIDTH;
	logic signed [MW-1:0] ab_s1 [3][3];
	logic signed [MW-1:0] as_s1 [3];
	logic signed [MW-1:0] c_s1, omc_s1;
	logic signed [COORD_WIDTH-1:0] p_s1 [3];

	function automatic logic signed [MW-1:0] rnd_ab(input logic signed [ABW-1:0] v);
		logic signed [ABW+MAT_FRAC:0] w;
		w = (ABW+MAT_FRAC+1)'(v);
		if (MAT_FRAC >= 2*AF) return MW'(w <<< (MAT_FRAC - 2*AF));
		return MW'((w + ((ABW+MAT_FRAC+1)'(1) <<< (2*AF-MAT_FRAC-1))) >>> (2*AF-MAT_FRAC));
	endfunction

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				as_s1[i] <= MW'(((AXIS_WIDTH+MW)'(a_d[NC][i]) * (AXIS_WIDTH+MW)'(sin_c)
					+ ((AXIS_WIDTH+MW)'(1) <<< (AF-1))) >>> AF);
				for (int j = 0; j < 3; j++) begin
					ab_s1[i][j] <= rnd_ab(ABW'(a_d[NC][i]) * ABW'(a_d[NC][j]));
				end
			end
			c_s1   <= cos_c;
			omc_s1 <= (MW'(1) <<< MAT_FRAC) - cos_c;
			p_s1   <= p_d[NC];
		end
	end

	// Stage 2: (1-cos)*ab rounded from Q.56 to Q.28, then the matrix.
	logic signed [MW-1:0] m_s2 [3][3];
	logic signed [COORD_WIDTH-1:0] p_s2 [3];
	logic signed [MW-1:0] t_c [3][3];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				t_c[i][j] = MW'(((2*MW)'(omc_s1) * (2*MW)'(ab_s1[i][j])
					+ ((2*MW)'(1) <<< (MAT_FRAC-1))) >>> MAT_FRAC);
			end
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			m_s2[0][0] <= c_s1 + t_c[0][0];
			m_s2[0][1] <= t_c[0][1] - as_s1[2];
			m_s2[0][2] <= t_c[0][2] + as_s1[1];
			m_s2[1][0] <= t_c[1][0] + as_s1[2];
			m_s2[1][1] <= c_s1 + t_c[1][1];
			m_s2[1][2] <= t_c[1][2] - as_s1[0];
			m_s2[2][0] <= t_c[2][0] - as_s1[1];
			m_s2[2][1] <= t_c[2][1] + as_s1[0];
			m_s2[2][2] <= c_s1 + t_c[2][2];
			p_s2 <= p_s1;
		end
	end

	// Stage 3: the nine products.
	logic signed [PW-1:0] pr_s3 [3][3];
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					pr_s3[i][j] <= PW'(m_s2[i][j]) * PW'(p_s2[j]);
				end
			end
		end
	end

	// Stage 4: row sums with rounding bias.
	logic signed [SW-1:0] sum_s4 [3];
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				sum_s4[i] <= SW'(pr_s3[i][0]) + SW'(pr_s3[i][1]) + SW'(pr_s3[i][2])
					+ (SW'(1) <<< (MAT_FRAC-1));
			end
		end
	end

	// Output register: shift down by 28 and saturate.
	localparam logic signed [SW-1:0] LIM_HI = SW'((64'sd1 <<< (COORD_WIDTH-1)) - 1);
	localparam logic signed [SW-1:0] LIM_LO = -SW'(64'sd1 <<< (COORD_WIDTH-1));
	logic signed [SW-1:0]          q_c [3];
	logic signed [COORD_WIDTH-1:0] sat_c [3];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			q_c[i] = sum_s4[i] >>> MAT_FRAC;
			if (q_c[i] > LIM_HI)      sat_c[i] = COORD_WIDTH'(LIM_HI);
			else if (q_c[i] < LIM_LO) sat_c[i] = COORD_WIDTH'(LIM_LO);
			else                      sat_c[i] = COORD_WIDTH'(q_c[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= vld_q[LAT-1];
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			rotated_x <= sat_c[0];
			rotated_y <= sat_c[1];
			rotated_z <= sat_c[2];
		end
	end

	// A held result word keeps the whole pipe frozen.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(vld_q))
		else $error("pipe moved while result word held");
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with empty output");
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall && !vld_q[LAT-1] |=> !out_valid)
		else $error("result word appeared from nowhere");

endmodule

// ===== src/rpa_cordic.sv =====
// ---------------------------------------------------------------------------
// rpa_cordic: pipelined rotation-mode CORDIC
// One micro-rotation per register stage; yields cos and sin in Q.28.
// ---------------------------------------------------------------------------
module rpa_cordic #(
	parameter int ANGLE_WIDTH = rpa_pkg::ANGLE_W_DEF,
	parameter int STAGES      = rpa_pkg::STAGES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             en,
	input  logic [ANGLE_WIDTH-1:0]           angle,
	output logic signed [rpa_pkg::MW-1:0]    cos_q,
	output logic signed [rpa_pkg::MW-1:0]    sin_q
);
	import rpa_pkg::*;

	localparam int N = (STAGES < TABLE_LEN) ? STAGES : TABLE_LEN;

	logic signed [CW-1:0] x_s [N+1];
	logic signed [CW-1:0] y_s [N+1];
	logic signed [ZW-1:0] z_s [N+1];
	logic                 neg_s [N+1];
	logic [31:0]          ph;
	logic [31:0]          ph_adj;
	logic                 fold;

	always_comb begin
		ph     = {angle, {(32-ANGLE_WIDTH){1'b0}}};
		fold   = ph[31] ^ ph[30];
		ph_adj = fold ? (ph - 32'h8000_0000) : ph;
	end

	assign x_s[0]   = CORDIC_START;
	assign y_s[0]   = '0;
	assign z_s[0]   = {ph_adj[31], ph_adj};
	assign neg_s[0] = fold;

	for (genvar i = 0; i < N; i++) begin : g_rot
		always_ff @(posedge clk) begin
			if (en) begin
				if (!z_s[i][ZW-1]) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - atan_lut(5'(i));
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + atan_lut(5'(i));
				end
				neg_s[i+1] <= neg_s[i];
			end
		end
	end

	// Negate folded angles, then round Q2.30 to Q.28 half up.
	logic signed [CW-1:0] xf, yf;
	always_comb begin
		xf    = neg_s[N] ? -x_s[N] : x_s[N];
		yf    = neg_s[N] ? -y_s[N] : y_s[N];
		cos_q = MW'((xf + CW'(2)) >>> 2);
		sin_q = MW'((yf + CW'(2)) >>> 2);
	end

	logic unused_z;
	assign unused_z = ^z_s[N] ^ arst_n;

endmodule

// ===== tb/rotate_point_about_axis_unit_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rotate_point_about_axis_unit_tb: self-checking bench for the rotation unit
// Drives points, axes and binary angles through the valid/stall handshake,
// predicts each rotated point with an in-bench CORDIC and matrix product,
// and compares every result word field by field, in order.
// ---------------------------------------------------------------------------
module rotate_point_about_axis_unit_tb;

	import rpa_pkg::*;

	localparam int LATENCY   = 16 + 5;
	localparam int CYCLE_CAP = 600000;

	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} point_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic signed [31:0] point_x, point_y, point_z;
	logic signed [15:0] axis_x, axis_y, axis_z;
	logic [15:0]        turn_angle;
	logic               out_valid;
	logic               out_stall;
	logic signed [31:0] rotated_x, rotated_y, rotated_z;

	// rotated points still owed by the block, oldest first
	point_t rotated_due[$];
	int     fail_count;
	int     cycle_count;
	// cycles the receiver must hold off, requested by the pressure test
	int     hold_request;

	rotate_point_about_axis_unit DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.point_x    (point_x),
		.point_y    (point_y),
		.point_z    (point_z),
		.axis_x     (axis_x),
		.axis_y     (axis_y),
		.axis_z     (axis_z),
		.turn_angle (turn_angle),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.rotated_x  (rotated_x),
		.rotated_y  (rotated_y),
		.rotated_z  (rotated_z)
	);

	// arctangent of 2^-i in units of 2^32 per turn
	longint atan_step [24] = '{
		64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
		64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
		64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
		64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
		64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
	};

	// Round a Q.28 row product sum to the point format and clamp it.
	function automatic logic signed [31:0] clamp_row(input longint m0, m1, m2,
			input longint p0, p1, p2);
		logic signed [127:0] acc;
		acc = m0 * p0;
		acc = acc + m1 * p1;
		acc = acc + m2 * p2;
		acc = (acc + 128'sd134217728) >>> 28;
		if (acc > 128'sd2147483647)
			return 32'sh7FFFFFFF;
		if (acc < -128'sd2147483648)
			return 32'sh80000000;
		return acc[31:0];
	endfunction

	// Rotate point p about axis a by a binary angle (Rodrigues matrix).
	function automatic point_t rotate_point(input point_t p,
			input logic signed [15:0] ax, ay, az, input logic [15:0] ang);
		longint    cx, cy, cz, dx, dy, c, s, omc;
		longint    a [3];
		longint    as [3];
		longint    t [3][3];
		logic [31:0] ph;
		bit        flip;
		point_t    r;
		ph = {ang, 16'b0};
		flip = 1'b0;
		// fold the left half plane onto the right one, negate at the end
		if (((ph + 32'h40000000) & 32'h80000000) != 0) begin
			ph = ph - 32'h80000000;
			flip = 1'b1;
		end
		cx = 652032874;
		cy = 0;
		cz = longint'($signed(ph));
		for (int i = 0; i < 16; i++) begin
			dx = cy >>> i;
			dy = cx >>> i;
			if (cz >= 0) begin
				cx -= dx; cy += dy; cz -= atan_step[i];
			end else begin
				cx += dx; cy -= dy; cz += atan_step[i];
			end
		end
		if (flip) begin
			cx = -cx;
			cy = -cy;
		end
		c = (cx + 2) >>> 2;
		s = (cy + 2) >>> 2;
		omc = (longint'(1) <<< 28) - c;
		a[0] = ax; a[1] = ay; a[2] = az;
		for (int i = 0; i < 3; i++) begin
			as[i] = (a[i] * s + (longint'(1) <<< 13)) >>> 14;
			for (int j = 0; j < 3; j++)
				t[i][j] = (omc * (a[i] * a[j]) + (longint'(1) <<< 27)) >>> 28;
		end
		r.x = clamp_row(c + t[0][0], t[0][1] - as[2], t[0][2] + as[1],
			p.x, p.y, p.z);
		r.y = clamp_row(t[1][0] + as[2], c + t[1][1], t[1][2] - as[0],
			p.x, p.y, p.z);
		r.z = clamp_row(t[2][0] - as[1], t[2][1] + as[0], c + t[2][2],
			p.x, p.y, p.z);
		return r;
	endfunction

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Abort a hung run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_CAP) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Record the expected rotation of every accepted input word.
	always @(posedge clk) begin
		point_t p;
		if (arst_n && in_valid && !in_stall) begin
			p.x = point_x; p.y = point_y; p.z = point_z;
			rotated_due.push_back(rotate_point(p, axis_x, axis_y, axis_z, turn_angle));
		end
	end

	// Check each accepted result word against the oldest prediction.
	always @(posedge clk) begin
		point_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (rotated_due.size() == 0) begin
				$error("result word with no prediction pending");
				fail_count++;
			end else begin
				e = rotated_due.pop_front();
				if (rotated_x !== e.x) begin
					$error("rotated_x expected %0d got %0d", e.x, rotated_x);
					fail_count++;
				end
				if (rotated_y !== e.y) begin
					$error("rotated_y expected %0d got %0d", e.y, rotated_y);
					fail_count++;
				end
				if (rotated_z !== e.z) begin
					$error("rotated_z expected %0d got %0d", e.z, rotated_z);
					fail_count++;
				end
			end
		end
	end

	// Receiver: random stalls, mostly short, with long holds on request.
	initial begin
		int hold_left, burst;
		out_stall = 1'b0;
		hold_left = 0;
		burst = 0;
		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				out_stall = 1'b1;
				hold_left--;
			end else if (burst > 0) begin
				// free-flowing stretch
				out_stall = 1'b0;
				burst--;
			end else begin
				case ($urandom_range(0, 19))
					0:       hold_left = $urandom_range(10, 40);
					1, 2:    burst = $urandom_range(20, 80);
					3, 4, 5: hold_left = $urandom_range(1, 3);
					default: ;
				endcase
				out_stall = (hold_left > 0);
				if (hold_left > 0)
					hold_left--;
			end
		end
	end

	// Offer one word, hold it until accepted, then idle a random gap (none when no_gap is set).
	task automatic send_word(input logic signed [31:0] px, py, pz,
			input logic signed [15:0] ax, ay, az, input logic [15:0] ang,
			input bit no_gap);
		int gap;
		point_x = px; point_y = py; point_z = pz;
		axis_x = ax; axis_y = ay; axis_z = az;
		turn_angle = ang;
		in_valid = 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		@(negedge clk);
		if (no_gap)
			gap = 0;
		else
			case ($urandom_range(0, 19))
				0:          gap = $urandom_range(15, 40);
				1, 2, 3, 4: gap = $urandom_range(1, 3);
				default:    gap = 0;
			endcase
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	function automatic logic signed [15:0] any_axis();
		return 16'(int'($urandom_range(0, 32768)) - 16384);
	endfunction

	function automatic logic signed [31:0] any_coord();
		// mostly modest coordinates, sometimes full range
		if ($urandom_range(0, 3) == 0)
			return $urandom;
		return 32'(int'($urandom_range(0, 2 * 200 * 65536)) - 200 * 65536);
	endfunction

	// Extremes of the point and angle fields, the quadrant edges, non-unit axes, clamping.
	task automatic test_directed();
		logic [15:0] edges [8] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000,
			16'h3FFF, 16'h4001, 16'hBFFF, 16'hFFFF};
		foreach (edges[i])
			send_word(32'sh00010000, 32'sh00020000, -32'sh00030000,
				16'sd0, 16'sd0, 16'sd16384, edges[i], 1'b0);
		send_word(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
			16'sd16384, 16'sd0, 16'sd0, 16'h0000, 1'b0);
		send_word(32'sh80000000, 32'sh80000000, 32'sh80000000,
			-16'sd16384, 16'sd0, 16'sd0, 16'h2000, 1'b0);
		// non-unit axis drives the sum past the coordinate range
		send_word(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
			16'sd16384, 16'sd16384, 16'sd16384, 16'h8000, 1'b0);
		send_word(32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000,
			-16'sd16384, -16'sd16384, -16'sd16384, 16'h6000, 1'b0);
		send_word(32'sh00000000, 32'sh00000000, 32'sh00000000,
			16'sd16384, -16'sd16384, 16'sd16384, 16'h1234, 1'b0);
		send_word(32'sh00000001, -32'sh00000001, 32'sh00000001,
			16'sd0, 16'sd16384, 16'sd0, 16'hFFFF, 1'b0);
		send_word(32'sh00A00000, 32'sh00000000, 32'sh00000000,
			16'sd0, 16'sd0, 16'sd0, 16'h4000, 1'b0);
		send_word(32'sh12345678, -32'sh0ABCDEF0, 32'sh00FFFFFF,
			16'sd9459, 16'sd9459, 16'sd9459, 16'hAAAA, 1'b0);
		send_word(32'sh55555555, 32'shAAAAAAAA, 32'sh5A5A5A5A,
			-16'sd1, 16'sd1, 16'sh5555, 16'h5555, 1'b0);
		send_word(-32'sh7FFFFFFF, 32'sh40000000, 32'sh00000000,
			16'sd11585, -16'sd11585, 16'sd0, 16'h7FFF, 1'b0);
	endtask

	// Random words: mostly unit axes along random directions, some arbitrary.
	task automatic test_random(input int count);
		logic signed [15:0] ax, ay, az;
		int k;
		for (int n = 0; n < count; n++) begin
			k = $urandom_range(0, 9);
			if (k < 6) begin
				// signed unit axis on a coordinate direction or diagonal
				ax = ($urandom_range(0, 1) ? 16'sd16384 : -16'sd16384);
				ay = ($urandom_range(0, 1) ? 16'sd9459 : -16'sd9459);
				az = ($urandom_range(0, 1) ? 16'sd11585 : -16'sd11585);
				case ($urandom_range(0, 3))
					0: begin ay = '0; az = '0; end
					1: begin ax = '0; az = '0; ay = ay[15] ? -16'sd16384 : 16'sd16384; end
					2: begin ax = '0; ay = ay[15] ? -16'sd11585 : 16'sd11585; end
					default: begin ax = ax[15] ? -16'sd9459 : 16'sd9459; az = az[15]
						? -16'sd9459 : 16'sd9459; end
				endcase
			end else begin
				ax = any_axis();
				ay = any_axis();
				az = any_axis();
			end
			send_word(any_coord(), any_coord(), any_coord(), ax, ay, az,
				16'($urandom), 1'b0);
		end
	endtask

	// Hold the receiver off long enough that the pipeline fills and stalls.
	task automatic test_backpressure();
		hold_request = 300;
		@(negedge clk);
		for (int n = 0; n < 60; n++)
			send_word(any_coord(), any_coord(), any_coord(), any_axis(),
				any_axis(), any_axis(), 16'($urandom), 1'b1);
	endtask

	initial begin
		fail_count = 0;
		cycle_count = 0;
		hold_request = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		point_x = '0; point_y = '0; point_z = '0;
		axis_x = '0; axis_y = '0; axis_z = '0;
		turn_angle = '0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_random(500);
		test_backpressure();
		test_random(470);
		in_valid = 1'b0;
		// drain, then give stray words a chance to show up
		while (rotated_due.size() != 0)
			@(negedge clk);
		repeat (LATENCY + 10) @(negedge clk);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
